FILE: hdl/isort_pkg.sv
package isort_pkg;

    localparam int DEPTH   = 32;
    localparam int VALUE_W = 32;
    localparam int POS_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index is paddr[2]
    localparam logic REG_ASCENDING = 1'b0;

    localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(DEPTH - 1);

    typedef struct packed {
        logic insert;   // place a new word into the chain
        logic shift;    // move every cell one step toward the head
        logic descend;  // chain keeps largest value first
    } chain_ctl_t;

endpackage

FILE: hdl/isort_cell.sv
module isort_cell
(
    input  logic                                clk,
    input  isort_pkg::chain_ctl_t               ctl,
    input  logic                                occupied,
    input  logic signed [isort_pkg::VALUE_W-1:0] in_value,
    input  logic [isort_pkg::POS_W-1:0]          in_pos,
    input  logic                                prev_after,
    input  logic signed [isort_pkg::VALUE_W-1:0] prev_value,
    input  logic [isort_pkg::POS_W-1:0]          prev_pos,
    input  logic signed [isort_pkg::VALUE_W-1:0] next_value,
    input  logic [isort_pkg::POS_W-1:0]          next_pos,
    output logic signed [isort_pkg::VALUE_W-1:0] value,
    output logic [isort_pkg::POS_W-1:0]          pos,
    output logic                                after
);

    logic signed [isort_pkg::VALUE_W-1:0] value_reg;
    logic signed [isort_pkg::VALUE_W-1:0] value_next;
    logic [isort_pkg::POS_W-1:0]          pos_reg;
    logic [isort_pkg::POS_W-1:0]          pos_next;

    // equal values stay ahead of the newcomer: stable order
    assign after = occupied && (ctl.descend ? (value_reg >= in_value)
                                            : (value_reg <= in_value));

    always_comb
    begin
        value_next = value_reg;
        pos_next   = pos_reg;
        priority if (ctl.shift)
        begin
            value_next = next_value;
            pos_next   = next_pos;
        end
        else if (ctl.insert && !after)
        begin
            if (prev_after)
            begin
                value_next = in_value;
                pos_next   = in_pos;
            end
            else
            begin
                value_next = prev_value;
                pos_next   = prev_pos;
            end
        end
        else
        begin
            value_next = value_reg;
            pos_next   = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign value = value_reg;
    assign pos   = pos_reg;

endmodule

FILE: hdl/isort_chain.sv
module isort_chain
(
    input  logic                                 clk,
    input  isort_pkg::chain_ctl_t                ctl,
    input  logic [isort_pkg::COUNT_W-1:0]         count,
    input  logic signed [isort_pkg::VALUE_W-1:0]  in_value,
    input  logic [isort_pkg::POS_W-1:0]           in_pos,
    output logic [isort_pkg::POS_W-1:0]           head_pos
);

    logic signed [isort_pkg::VALUE_W-1:0] vals  [isort_pkg::DEPTH];
    logic [isort_pkg::POS_W-1:0]          poss  [isort_pkg::DEPTH];
    logic                                 afts  [isort_pkg::DEPTH];

    genvar k;
    generate
        for (k = 0; k < isort_pkg::DEPTH; k++)
        begin : g_cell
            logic                                 prev_after;
            logic signed [isort_pkg::VALUE_W-1:0] prev_value;
            logic [isort_pkg::POS_W-1:0]          prev_pos;
            logic signed [isort_pkg::VALUE_W-1:0] next_value;
            logic [isort_pkg::POS_W-1:0]          next_pos;
            logic                                 occupied;

            assign occupied = (isort_pkg::COUNT_W'(k) < count);

            if (k == 0)
            begin : g_head
                assign prev_after = 1'b1;
                assign prev_value = in_value;
                assign prev_pos   = in_pos;
            end
            else
            begin : g_body
                assign prev_after = afts[k-1];
                assign prev_value = vals[k-1];
                assign prev_pos   = poss[k-1];
            end

            if (k == isort_pkg::DEPTH - 1)
            begin : g_tail
                assign next_value = '0;
                assign next_pos   = '0;
            end
            else
            begin : g_inner
                assign next_value = vals[k+1];
                assign next_pos   = poss[k+1];
            end

            isort_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (occupied),
                .in_value   (in_value),
                .in_pos     (in_pos),
                .prev_after (prev_after),
                .prev_value (prev_value),
                .prev_pos   (prev_pos),
                .next_value (next_value),
                .next_pos   (next_pos),
                .value      (vals[k]),
                .pos        (poss[k]),
                .after      (afts[k])
            );
        end
    endgenerate

    assign head_pos = poss[0];

endmodule

FILE: hdl/index_sort.sv
// index_sort: stable argsort over one set of up to DEPTH words.
// Loading: one word per cycle (busy low), each word dropped into its sorted
//   place in two insertion chains (ascending and descending) in that cycle.
// Closing word (end_of_set, or the DEPTH-th word): its n results follow it
//   back to back, one per cycle, with busy high exactly while they are emitted.
// Reset clears the word count, the emit state and sets ascending to 1.
module index_sort
(
    input  logic                               clk,
    input  logic                               rst_n,
    // command side
    input  logic                               start,
    output logic                               busy,
    input  logic signed [isort_pkg::VALUE_W-1:0] sample_value,
    input  logic                               end_of_set,
    // result side, one word per strobe, cannot be held off
    output logic                               result_valid,
    output logic [isort_pkg::POS_W-1:0]          position,
    output logic                               final_position,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [isort_pkg::PADDR_W-1:0]        paddr,
    input  logic [isort_pkg::PDATA_W-1:0]        pwdata,
    output logic [isort_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    // configuration register
    logic ascending_reg;
    logic ascending_next;

    // load and emit control
    logic [isort_pkg::COUNT_W-1:0] count_reg;
    logic [isort_pkg::COUNT_W-1:0] count_next;
    logic                          emit_reg;
    logic                          emit_next;
    logic [isort_pkg::COUNT_W-1:0] emit_left_reg;
    logic [isort_pkg::COUNT_W-1:0] emit_left_next;
    logic                          desc_sel_reg;
    logic                          desc_sel_next;

    logic accept;
    logic close_set;
    logic cfg_write;

    isort_pkg::chain_ctl_t        asc_ctl;
    isort_pkg::chain_ctl_t        desc_ctl;
    logic [isort_pkg::POS_W-1:0]  asc_head;
    logic [isort_pkg::POS_W-1:0]  desc_head;

    // ---------------- APB register ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        ascending_next = ascending_reg;
        if (cfg_write && (paddr[2] == isort_pkg::REG_ASCENDING))
        begin
            ascending_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == isort_pkg::REG_ASCENDING)
        begin
            prdata[0] = ascending_reg;
        end
    end

    // ---------------- load / emit control ----------------
    // A word is accepted only when not emitting; a set is capped at DEPTH words
    // by closing it on the DEPTH-th word.
    assign accept    = start && !busy;
    assign close_set = accept && (end_of_set || (count_reg == isort_pkg::COUNT_LAST));

    always_comb
    begin
        count_next     = count_reg;
        emit_next      = emit_reg;
        emit_left_next = emit_left_reg;
        desc_sel_next  = desc_sel_reg;
        priority if (close_set)
        begin
            // direction is whatever the register says at the closing word
            count_next     = isort_pkg::COUNT_ZERO;
            emit_next      = 1'b1;
            emit_left_next = count_reg + isort_pkg::COUNT_ONE;
            desc_sel_next  = !ascending_reg;
        end
        else if (accept)
        begin
            count_next = count_reg + isort_pkg::COUNT_ONE;
        end
        else if (emit_reg)
        begin
            emit_left_next = emit_left_reg - isort_pkg::COUNT_ONE;
            if (emit_left_reg == isort_pkg::COUNT_ONE)
            begin
                emit_next = 1'b0;
            end
        end
        else
        begin
            // idle: nothing moves
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascending_reg <= 1'b1;
            count_reg     <= '0;
            emit_reg      <= 1'b0;
            emit_left_reg <= '0;
            desc_sel_reg  <= 1'b0;
        end
        else
        begin
            ascending_reg <= ascending_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            emit_left_reg <= emit_left_next;
            desc_sel_reg  <= desc_sel_next;
        end
    end

    // ---------------- insertion chains ----------------
    // Both orders are kept so the direction can be picked at the closing word
    // while ties stay earliest-first in either direction.
    assign asc_ctl.insert  = accept;
    assign asc_ctl.shift   = emit_reg;
    assign asc_ctl.descend = 1'b0;

    assign desc_ctl.insert  = accept;
    assign desc_ctl.shift   = emit_reg;
    assign desc_ctl.descend = 1'b1;

    isort_chain u_asc_chain
    (
        .clk      (clk),
        .ctl      (asc_ctl),
        .count    (count_reg),
        .in_value (sample_value),
        .in_pos   (count_reg[isort_pkg::POS_W-1:0]),
        .head_pos (asc_head)
    );

    isort_chain u_desc_chain
    (
        .clk      (clk),
        .ctl      (desc_ctl),
        .count    (count_reg),
        .in_value (sample_value),
        .in_pos   (count_reg[isort_pkg::POS_W-1:0]),
        .head_pos (desc_head)
    );

    // ---------------- outputs ----------------
    // heads shift out one cell per emit cycle
    assign busy           = emit_reg;
    assign result_valid   = emit_reg;
    assign position       = desc_sel_reg ? desc_head : asc_head;
    assign final_position = emit_reg && (emit_left_reg == isort_pkg::COUNT_ONE);

endmodule

FILE: hdl/isort_check.sv
module isort_check
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic end_of_set,
    input  logic result_valid,
    input  logic final_position
);

    a_final_is_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        final_position |-> result_valid)
        else $error("final_position without result_valid");

    a_close_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && end_of_set) |=> result_valid)
        else $error("closing word not followed by results");

    a_run_is_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !final_position) |=> result_valid)
        else $error("result run broken before final word");

    a_run_ends_at_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_position) |=> !result_valid)
        else $error("results continue after final word");

    a_busy_drops_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(final_position))
        else $error("busy dropped without a final word");

endmodule

bind index_sort isort_check u_isort_check
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .end_of_set     (end_of_set),
    .result_valid   (result_valid),
    .final_position (final_position)
);
